// ----- sv/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper and its decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  localparam int ChrSlots = 8;

  typedef enum logic [1:0] {
    CMD_CPU_READ  = 2'd0,
    CMD_CPU_WRITE = 2'd1,
    CMD_PPU_READ  = 2'd2,
    CMD_PPU_WRITE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REGION_NONE    = 2'd0,
    REGION_PRG_RAM = 2'd1,
    REGION_PRG_ROM = 2'd2,
    REGION_CHR     = 2'd3
  } region_e;

  typedef enum logic [2:0] {
    CFG_PRG_SIZE    = 3'd0,
    CFG_CHR_SIZE    = 3'd1,
    CFG_CHR_IS_RAM  = 3'd2,
    CFG_RAM_PRESENT = 3'd3,
    CFG_BATTERY     = 3'd4
  } cfg_index_e;

  // mapper register decode, address masked with RegMask
  localparam logic [15:0] RegMask     = 16'hF003;
  localparam logic [15:0] RegPrgBank  = 16'h8000;
  localparam logic [15:0] RegIrqLatch = 16'hF000;
  localparam logic [15:0] RegIrqCtrl  = 16'hF002;
  localparam logic [15:0] RegIrqAck   = 16'hF001;
  localparam logic [3:0]  RegChrLoHi  = 4'hD;
  localparam logic [3:0]  RegChrHiHi  = 4'hE;

  localparam logic [7:0]  CountTop    = 8'hFF;
  localparam logic [8:0]  SizeMax     = 9'd256;

  typedef struct packed {
    logic [8:0] prg_size;
    logic [8:0] chr_size;
    logic       chr_is_ram;
    logic       ram_present;
    logic       battery;
  } cfg_t;

  typedef struct packed {
    logic [7:0]                 prg_bank;
    logic [ChrSlots-1:0][7:0]   chr_bank;
    logic [7:0]                 irq_reload;
    logic [7:0]                 irq_count;
    logic [1:0]                 irq_en_bits;
    logic                       irq_flag;
  } map_state_t;

  typedef struct packed {
    logic       pending;
    logic       irq_raise;
    logic       mark_dirty;
    logic       write_strobe;
    logic [21:0] mem_offset;
    region_e    region;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/cbm_decode.sv -----
// ----------------------------------------------------------------------------
// cbm_decode
// Decodes one bus access or scanline tick against the mapper state: target
// region, byte offset, strobes, and the updated bank and irq registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_decode (
  input  cbm_pkg::cfg_t       cfg,
  input  cbm_pkg::map_state_t st,
  input  logic [1:0]          command,
  input  logic [15:0]         address,
  input  logic [7:0]          data,
  output cbm_pkg::map_state_t st_next,
  output cbm_pkg::result_t    res
);

  cbm_pkg::cmd_e cmd;
  logic [8:0]    prg_sat;
  logic [8:0]    chr_sat;
  logic [21:0]   prg_off;
  logic [21:0]   fixed_off;
  logic          prg_in_range;
  logic [17:0]   chr_off;
  logic          chr_in_range;
  logic [15:0]   rw_a;
  logic [1:0]    rw_idx;

  assign cmd          = cbm_pkg::cmd_e'(command);
  assign prg_sat      = (cfg.prg_size > cbm_pkg::SizeMax) ? cbm_pkg::SizeMax : cfg.prg_size;
  assign chr_sat      = (cfg.chr_size > cbm_pkg::SizeMax) ? cbm_pkg::SizeMax : cfg.chr_size;
  assign prg_off      = {st.prg_bank, address[13:0]};
  assign prg_in_range = {1'b0, prg_off} < {prg_sat, 14'd0};
  // last 16k bank; a size of 256 wraps the low byte to zero, minus one gives ff
  assign fixed_off    = {prg_sat[7:0] - 8'd1, address[13:0]};
  assign chr_off      = {st.chr_bank[address[12:10]], address[9:0]};
  assign chr_in_range = {1'b0, chr_off} < {chr_sat, 10'd0};
  assign rw_a         = address & cbm_pkg::RegMask;
  // a0 and a1 swapped on the board
  assign rw_idx       = {rw_a[0], rw_a[1]};

  always_comb begin
    st_next          = st;
    res              = '0;
    res.region       = cbm_pkg::REGION_NONE;
    if (cmd == cbm_pkg::CMD_PPU_WRITE && address[15]) begin
      // scanline tick
      if (st.irq_en_bits[1]) begin
        if (st.irq_count == cbm_pkg::CountTop) begin
          st_next.irq_count = st.irq_reload;
          st_next.irq_flag  = 1'b1;
          res.irq_raise     = 1'b1;
        end else begin
          st_next.irq_count = st.irq_count + 8'd1;
        end
      end
    end else if (cmd == cbm_pkg::CMD_CPU_READ || cmd == cbm_pkg::CMD_CPU_WRITE) begin
      if (address[15:13] == 3'b011) begin
        if (cfg.ram_present) begin
          res.region = cbm_pkg::REGION_PRG_RAM;
          res.mem_offset = {9'd0, address[12:0]};
          if (cmd == cbm_pkg::CMD_CPU_WRITE) begin
            res.write_strobe = 1'b1;
            res.mark_dirty   = cfg.battery;
          end
        end
      end else if (address[15]) begin
        if (cmd == cbm_pkg::CMD_CPU_WRITE) begin
          if (rw_a == cbm_pkg::RegPrgBank) begin
            st_next.prg_bank = data;
          end else if (rw_a[15:12] == cbm_pkg::RegChrLoHi) begin
            st_next.chr_bank[{1'b0, rw_idx}] = data;
          end else if (rw_a[15:12] == cbm_pkg::RegChrHiHi) begin
            st_next.chr_bank[{1'b1, rw_idx}] = data;
          end else if (rw_a == cbm_pkg::RegIrqLatch) begin
            st_next.irq_reload = data;
          end else if (rw_a == cbm_pkg::RegIrqCtrl) begin
            st_next.irq_en_bits = data[1:0];
            if (data[1]) begin
              st_next.irq_count = st.irq_reload;
            end
            st_next.irq_flag = 1'b0;
          end else if (rw_a == cbm_pkg::RegIrqAck) begin
            st_next.irq_flag    = 1'b0;
            st_next.irq_en_bits = {st.irq_en_bits[0], st.irq_en_bits[0]};
          end
        end else if (!address[14]) begin
          if (prg_in_range) begin
            res.region     = cbm_pkg::REGION_PRG_ROM;
            res.mem_offset = prg_off;
          end
        end else if (prg_sat != 9'd0) begin
          res.region     = cbm_pkg::REGION_PRG_ROM;
          res.mem_offset = fixed_off;
        end
      end
    end else begin
      // ppu pattern space only, 2000-3fff maps nowhere
      if (!address[13] && chr_in_range) begin
        if (cmd == cbm_pkg::CMD_PPU_READ) begin
          res.region     = cbm_pkg::REGION_CHR;
          res.mem_offset = {4'd0, chr_off};
        end else if (cfg.chr_is_ram) begin
          res.region       = cbm_pkg::REGION_CHR;
          res.mem_offset   = {4'd0, chr_off};
          res.write_strobe = 1'b1;
        end
      end
    end
    res.pending = st_next.irq_flag;
  end

endmodule

`default_nettype wire

// ----- sv/cartridge_bank_mapper_irq.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Cartridge bank mapper with scanline irq counter: maps cpu and ppu accesses
// to prg ram, prg rom or chr memory and handles the mapper registers.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser: command; tdata: address[15:0], data[23:16]
//  m_*      | out       | tdata: region, mem_offset, write_strobe, mark_dirty,
//           |           |        irq_raise, pending (from bit 0 up)
//  cfg_*    | in        | register write, index 0..4, no read-back
//
//  one transaction per cycle sustained while m_tready stays high; an item passes
//  through the input register, decode and the result register
//  mapper state updates as the item leaves the input register
//  a stall on m_tready holds the result and then the input register; s_tready
//  drops only when both are full
//  rst is synchronous: banks and irq clear, config 32k prg, 8k chr rom, ram, no battery
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // region[1:0], mem_offset[23:2], write_strobe[24],
                                 // mark_dirty[25], irq_raise[26], pending[27]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cbm_pkg::cfg_t       cfg;
  cbm_pkg::map_state_t st;
  cbm_pkg::map_state_t st_next;
  cbm_pkg::result_t    res;
  cbm_pkg::result_t    out_res;

  logic        in_valid;
  logic [1:0]  in_command;
  logic [15:0] in_address;
  logic [7:0]  in_data;
  logic        advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_size    <= 9'd2;
      cfg.chr_size    <= 9'd8;
      cfg.chr_is_ram  <= 1'b0;
      cfg.ram_present <= 1'b1;
      cfg.battery     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cbm_pkg::cfg_index_e'(cfg_index))
        cbm_pkg::CFG_PRG_SIZE:    cfg.prg_size    <= cfg_data;
        cbm_pkg::CFG_CHR_SIZE:    cfg.chr_size    <= cfg_data;
        cbm_pkg::CFG_CHR_IS_RAM:  cfg.chr_is_ram  <= cfg_data[0];
        cbm_pkg::CFG_RAM_PRESENT: cfg.ram_present <= cfg_data[0];
        cbm_pkg::CFG_BATTERY:     cfg.battery     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_command <= s_tuser;
      in_address <= s_tdata[15:0];
      in_data    <= s_tdata[23:16];
    end
  end

  cbm_decode u_decode (
    .cfg     (cfg),
    .st      (st),
    .command (in_command),
    .address (in_address),
    .data    (in_data),
    .st_next (st_next),
    .res     (res)
  );

  // mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'd0, out_res};

endmodule

`default_nettype wire

// ----- test/cartridge_bank_mapper_irq_test.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_test
// Self-checking bench for the bank mapper: a queue-fed stream driver, a result
// monitor and a transaction-level mapper predictor updated per accepted access.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_irq_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] RamBase   = 16'h6000;
  localparam logic [15:0] RomBase   = 16'h8000;
  localparam logic [15:0] FixedBase = 16'hC000;
  localparam logic [31:0] PrgUnit   = 32'h4000;
  localparam logic [31:0] ChrUnit   = 32'h400;
  localparam int          CycleLimit = 200000;
  localparam int          LongHold   = 300;
  localparam int          TailWait   = 10;
  localparam int          PhaseItems = 62;

  typedef struct packed {
    cbm_pkg::cmd_e cmd;
    logic [15:0]   addr;
    logic [7:0]    data;
  } access_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // address[15:0], data[23:16]
  logic [1:0]  s_tuser = '0;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // region, mem_offset, write_strobe, mark_dirty,
                               // irq_raise, pending (from bit 0 up)
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  cartridge_bank_mapper_irq u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mapper state mirror and configuration copy
  cbm_pkg::cfg_t cfg_now = '{prg_size: 9'd2, chr_size: 9'd8, chr_is_ram: 1'b0,
                             ram_present: 1'b1, battery: 1'b0};
  logic [7:0] bank_prg = '0;
  logic [7:0] bank_chr [cbm_pkg::ChrSlots] = '{default: '0};
  logic [7:0] tick_reload = '0;
  logic [7:0] tick_count = '0;
  logic [1:0] irq_en = '0;
  logic       irq_pend = 1'b0;

  access_t access_q [$];
  cbm_pkg::result_t expected_results [$];
  access_t cur_access;
  logic    item_held = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int irq_seen = 0;
  int cycle_count = 0;
  int cfg_writes = 0;

  logic [15:0] reg_addrs [12] = '{16'h8000, 16'hD000, 16'hD001, 16'hD002, 16'hD003,
                                  16'hE000, 16'hE001, 16'hE002, 16'hE003,
                                  16'hF000, 16'hF001, 16'hF002};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // decode one access and advance the mapper state the way the block does
  function automatic cbm_pkg::result_t map_access(access_t it);
    cbm_pkg::result_t r;
    logic [15:0] a;
    logic [1:0]  sel;
    logic [31:0] prg_lim;
    logic [31:0] chr_lim;
    logic [31:0] o;
    logic [13:0] pa;
    r = '0;
    prg_lim = 32'((cfg_now.prg_size > cbm_pkg::SizeMax) ? cbm_pkg::SizeMax
                                                        : cfg_now.prg_size) * PrgUnit;
    chr_lim = 32'((cfg_now.chr_size > cbm_pkg::SizeMax) ? cbm_pkg::SizeMax
                                                        : cfg_now.chr_size) * ChrUnit;
    if (it.cmd == cbm_pkg::CMD_PPU_WRITE && it.addr[15]) begin
      // scanline tick
      if (irq_en[1]) begin
        if (tick_count == cbm_pkg::CountTop) begin
          tick_count = tick_reload;
          irq_pend = 1'b1;
          r.irq_raise = 1'b1;
        end else begin
          tick_count = tick_count + 8'd1;
        end
      end
    end else if (it.cmd == cbm_pkg::CMD_CPU_READ || it.cmd == cbm_pkg::CMD_CPU_WRITE) begin
      if (it.addr >= RamBase && it.addr < RomBase) begin
        if (cfg_now.ram_present) begin
          r.region = cbm_pkg::REGION_PRG_RAM;
          r.mem_offset = 22'(it.addr - RamBase);
          if (it.cmd == cbm_pkg::CMD_CPU_WRITE) begin
            r.write_strobe = 1'b1;
            r.mark_dirty = cfg_now.battery;
          end
        end
      end else if (it.addr >= RomBase) begin
        if (it.cmd == cbm_pkg::CMD_CPU_WRITE) begin
          a = it.addr & cbm_pkg::RegMask;
          // chr slot index takes A0 and A1 swapped
          sel = {a[0], a[1]};
          if (a == cbm_pkg::RegPrgBank) begin
            bank_prg = it.data;
          end else if (a[15:12] == cbm_pkg::RegChrLoHi) begin
            bank_chr[{1'b0, sel}] = it.data;
          end else if (a[15:12] == cbm_pkg::RegChrHiHi) begin
            bank_chr[{1'b1, sel}] = it.data;
          end else if (a == cbm_pkg::RegIrqLatch) begin
            tick_reload = it.data;
          end else if (a == cbm_pkg::RegIrqCtrl) begin
            irq_en = it.data[1:0];
            if (irq_en[1]) tick_count = tick_reload;
            irq_pend = 1'b0;
          end else if (a == cbm_pkg::RegIrqAck) begin
            irq_pend = 1'b0;
            irq_en = {irq_en[0], irq_en[0]};
          end
        end else if (it.addr < FixedBase) begin
          o = 32'(bank_prg) * PrgUnit + 32'(it.addr - RomBase);
          if (o < prg_lim) begin
            r.region = cbm_pkg::REGION_PRG_ROM;
            r.mem_offset = 22'(o);
          end
        end else if (prg_lim >= PrgUnit) begin
          r.region = cbm_pkg::REGION_PRG_ROM;
          r.mem_offset = 22'(prg_lim - PrgUnit + 32'(it.addr - FixedBase));
        end
      end
    end else begin
      pa = it.addr[13:0];
      if (!pa[13]) begin
        o = 32'(bank_chr[pa[12:10]]) * ChrUnit + 32'(pa[9:0]);
        if (o < chr_lim) begin
          if (it.cmd == cbm_pkg::CMD_PPU_READ) begin
            r.region = cbm_pkg::REGION_CHR;
            r.mem_offset = 22'(o);
          end else if (cfg_now.chr_is_ram) begin
            r.region = cbm_pkg::REGION_CHR;
            r.mem_offset = 22'(o);
            r.write_strobe = 1'b1;
          end
        end
      end
    end
    r.pending = irq_pend;
    return r;
  endfunction

  // mostly well-formed traffic: register programming, ticks, in-range accesses
  function automatic access_t random_access();
    access_t it;
    int      pick;
    logic [15:0] base;
    pick = $urandom_range(99);
    it.data = 8'($urandom);
    if (pick < 22) begin
      base = reg_addrs[$urandom_range(11)];
      it.cmd = cbm_pkg::CMD_CPU_WRITE;
      it.addr = base | (16'($urandom) & 16'h0FFC);
      if (base == cbm_pkg::RegIrqLatch)
        it.data = ($urandom_range(3) != 0) ? 8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom);
      else if (base != cbm_pkg::RegIrqCtrl && base != cbm_pkg::RegIrqAck &&
               $urandom_range(1))
        it.data = 8'($urandom_range(3));
    end else if (pick < 45) begin
      it.cmd = cbm_pkg::CMD_PPU_WRITE;
      it.addr = 16'h8000 | 16'($urandom);
    end else if (pick < 65) begin
      it.cmd = $urandom_range(1) ? cbm_pkg::CMD_CPU_READ : cbm_pkg::CMD_CPU_WRITE;
      if (it.cmd == cbm_pkg::CMD_CPU_WRITE) it.addr = 16'($urandom_range(RamBase, RomBase - 1));
      else it.addr = 16'($urandom_range(RamBase, 16'hFFFF));
    end else if (pick < 88) begin
      it.cmd = $urandom_range(1) ? cbm_pkg::CMD_PPU_READ : cbm_pkg::CMD_PPU_WRITE;
      it.addr = 16'($urandom) & (($urandom_range(4) != 0) ? 16'h1FFF : 16'h7FFF);
    end else begin
      it.cmd = cbm_pkg::cmd_e'($urandom_range(3));
      it.addr = 16'($urandom);
    end
    return it;
  endfunction

  task automatic queue_access(cbm_pkg::cmd_e cmd, logic [15:0] addr, logic [7:0] data);
    access_q.push_back('{cmd: cmd, addr: addr, data: data});
  endtask

  task automatic drain();
    while (access_q.size() != 0 || item_held || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_cfg(cbm_pkg::cfg_index_e idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      cbm_pkg::CFG_PRG_SIZE:    cfg_now.prg_size = val;
      cbm_pkg::CFG_CHR_SIZE:    cfg_now.chr_size = val;
      cbm_pkg::CFG_CHR_IS_RAM:  cfg_now.chr_is_ram = val[0];
      cbm_pkg::CFG_RAM_PRESENT: cfg_now.ram_present = val[0];
      cbm_pkg::CFG_BATTERY:     cfg_now.battery = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [8:0] prg, logic [8:0] chr, logic chr_ram,
                            logic ram, logic batt);
    write_cfg(cbm_pkg::CFG_PRG_SIZE, prg);
    write_cfg(cbm_pkg::CFG_CHR_SIZE, chr);
    write_cfg(cbm_pkg::CFG_CHR_IS_RAM, {8'd0, chr_ram});
    write_cfg(cbm_pkg::CFG_RAM_PRESENT, {8'd0, ram});
    write_cfg(cbm_pkg::CFG_BATTERY, {8'd0, batt});
  endtask

  task automatic run_phase(int send_idle, int recv_stall);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    repeat (PhaseItems) access_q.push_back(random_access());
    drain();
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        expected_results.push_back(map_access(cur_access));
        accepted_count++;
        item_held = 1'b0;
      end
      if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_access = access_q.pop_front();
        item_held = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata <= {cur_access.data, cur_access.addr};
        s_tuser <= cur_access.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    cbm_pkg::result_t got;
    cbm_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = cbm_pkg::result_t'(m_tdata[27:0]);
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none actual %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("region", want.region, got.region);
          check_field("mem_offset", want.mem_offset, got.mem_offset);
          check_field("write_strobe", want.write_strobe, got.write_strobe);
          check_field("mark_dirty", want.mark_dirty, got.mark_dirty);
          check_field("irq_raise", want.irq_raise, got.irq_raise);
          check_field("pending", want.pending, got.pending);
          checked_count++;
          if (want.irq_raise) irq_seen++;
        end
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: 32k prg, 8k chr rom, ram present, no battery
    queue_access(cbm_pkg::CMD_CPU_READ,  16'h0000, 8'h00);  // below save ram
    queue_access(cbm_pkg::CMD_CPU_READ,  16'h5FFF, 8'h00);
    queue_access(cbm_pkg::CMD_CPU_READ,  16'h6000, 8'h00);
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'h7FFF, 8'hFF);
    queue_access(cbm_pkg::CMD_CPU_READ,  16'h8000, 8'h00);
    queue_access(cbm_pkg::CMD_CPU_READ,  16'hFFFF, 8'h00);  // fixed last bank
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'h8000, 8'h01);
    queue_access(cbm_pkg::CMD_CPU_READ,  16'hBFFF, 8'h00);
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'h8FFC, 8'hFF);  // mirrored prg bank, out of range
    queue_access(cbm_pkg::CMD_CPU_READ,  16'h8000, 8'h00);
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hD000, 8'h07);
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hEFF7, 8'h05);  // mirror of last chr slot
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hD001, 8'h20);  // slot 2, beyond chr size
    queue_access(cbm_pkg::CMD_PPU_READ,  16'h0000, 8'h00);
    queue_access(cbm_pkg::CMD_PPU_READ,  16'h1FFF, 8'h00);
    queue_access(cbm_pkg::CMD_PPU_READ,  16'h0800, 8'h00);
    queue_access(cbm_pkg::CMD_PPU_WRITE, 16'h03FF, 8'hAA);  // write to chr rom
    queue_access(cbm_pkg::CMD_PPU_READ,  16'h7FFF, 8'h00);  // nametable space
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hF000, 8'hFE);
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hF002, 8'h03);
    queue_access(cbm_pkg::CMD_PPU_WRITE, 16'h8000, 8'h00);
    queue_access(cbm_pkg::CMD_PPU_WRITE, 16'hFFFF, 8'h00);  // counter wraps, irq fires
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hF001, 8'h00);
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hF002, 8'h00);
    queue_access(cbm_pkg::CMD_PPU_WRITE, 16'h8001, 8'h00);  // tick while disabled
    queue_access(cbm_pkg::CMD_CPU_WRITE, 16'hFFFF, 8'h55);  // unused register
    drain();

    set_config(9'd1, 9'd0, 1'b1, 1'b0, 1'b1);
    run_phase(60, 0);
    set_config(9'd256, 9'd256, 1'b0, 1'b1, 1'b1);
    run_phase(0, 60);
    set_config(9'h1FF, 9'h1FF, 1'b1, 1'b1, 1'b0);
    run_phase(10, 10);
    set_config(9'd0, 9'd1, 1'b1, 1'b1, 1'b1);
    hold_req = 1'b1;   // receiver parks while the sender keeps pushing
    run_phase(0, 0);
    set_config(9'd4, 9'd16, 1'b0, 1'b1, 1'b0);
    run_phase(60, 60);
    set_config(9'($urandom_range(1, 256)), 9'($urandom_range(0, 256)),
               1'($urandom), 1'($urandom), 1'($urandom));
    run_phase(10, 10);

    repeat (TailWait) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0t missing transactions: expected %0d actual 0", $time,
               expected_results.size());
    end
    $display("covered %0d accesses under %0d register writes; %0d results compared",
             accepted_count, cfg_writes, checked_count);
    $display("irq raises seen: %0d, with a long receiver hold-off", irq_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
